@@ hdl/csnm_pkg.sv @@
// shared types, constants and helpers for the c symbol name mangler
package csnm_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IDX_W       = 2;

    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_X          = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5a;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7a;

    typedef enum logic [1:0] {
        CMD_PASS,
        CMD_US1,
        CMD_US2,
        CMD_ESC
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] ch;
        logic              name_end;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_UPPER_A + {4'd0, nib - 4'd10};
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] last_index(input cmd_kind_t kind);
        logic [IDX_W-1:0] r;
        unique case (kind)
            CMD_PASS: r = 2'd0;
            CMD_US1:  r = 2'd0;
            CMD_US2:  r = 2'd1;
            CMD_ESC:  r = 2'd3;
            default:  r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/c_symbol_name_mangler.sv @@
// top level of the c symbol name mangler
// the first output word of a byte is held in the command queue and then in the output register
// one output word per cycle while m_tready is high; a byte gives 1, 2 or 4 words (4 when escaped)
// the output word rate of the back end sets the sustained byte rate
// reset: synchronous active-low aresetn empties the queue and output register,
// clears double underscore mode and restarts the name scan
module c_symbol_name_mangler (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_char
    input  logic       s_tlast,   // in_name_end
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,  // double_underscore_mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char
    output logic       m_tuser,   // out_run_last
    output logic       m_tlast    // out_name_end
);
    import csnm_pkg::*;

    cmd_t    push_cmd, head_cmd;
    q_stat_t q_stat;
    logic    push, pop;

    csnm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_stat.full),
        .push      (push),
        .cmd       (push_cmd)
    );

    csnm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    csnm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    a_name_end_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("name end on a word that does not close its run");

    a_inner_word_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> ((m_tdata >= CH_ZERO) && (m_tdata <= CH_NINE))
            || ((m_tdata >= CH_UPPER_A) && (m_tdata <= CH_UPPER_F))
            || (m_tdata == CH_X) || (m_tdata == CH_UNDERSCORE))
        else $error("unexpected byte inside an expanded run");

    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full && !pop |=> !q_stat.empty && $stable(head_cmd))
        else $error("queue head changed while full without a pop");
`endif

endmodule

@@ hdl/csnm_front.sv @@
// front end: accepts name bytes, tracks scan state and classifies each byte
module csnm_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // in_char
    input  logic                           s_tlast,   // in_name_end
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,  // double_underscore_mode
    input  logic                           q_full,
    output logic                           push,
    output csnm_pkg::cmd_t                 cmd
);
    import csnm_pkg::*;

    typedef enum logic [1:0] {
        PH_ANY,
        PH_ZERO,
        PH_ZERO_X,
        PH_HEX
    } phase_t;

    phase_t phase_reg, phase_next, phase_scan;
    logic   prev_us_reg, prev_us_next;
    logic   start_reg, start_next;
    logic   dbl_reg;

    logic [CHAR_W-1:0] c;
    logic is_digit, is_alnum, is_uhex, is_us, escape, accept;

    assign c         = s_tdata;
    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign push      = accept;

    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_uhex  = is_digit || ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
    assign is_alnum = is_digit || ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
                    || ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    assign is_us    = (c == CH_UNDERSCORE);

    always_comb begin
        unique case (phase_reg)
            PH_ZERO:   phase_scan = (c == CH_X) ? PH_ZERO_X : PH_ANY;
            PH_ZERO_X: phase_scan = is_uhex ? PH_HEX : PH_ANY;
            default:   phase_scan = (c == CH_ZERO) ? PH_ZERO : PH_ANY;
        endcase
    end

    always_comb begin
        escape       = 1'b0;
        prev_us_next = prev_us_reg;
        cmd.kind     = CMD_PASS;
        cmd.ch       = c;
        cmd.name_end = s_tlast;
        priority if (phase_scan == PH_HEX) begin
            escape = 1'b1;
        end else if (is_us && (start_reg || s_tlast || prev_us_reg)) begin
            escape = 1'b1;
        end else if (is_us) begin
            cmd.kind     = dbl_reg ? CMD_US2 : CMD_US1;
            prev_us_next = 1'b1;
        end else if (is_alnum) begin
            prev_us_next = 1'b0;
        end else begin
            escape = 1'b1;
        end
        phase_next = phase_scan;
        if (escape) begin
            cmd.kind     = CMD_ESC;
            prev_us_next = 1'b0;
            phase_next   = PH_ANY;
        end
        start_next = s_tlast;
        if (s_tlast) begin
            phase_next   = PH_ANY;
            prev_us_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_ANY;
            prev_us_reg <= 1'b0;
            start_reg   <= 1'b1;
            dbl_reg     <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                prev_us_reg <= prev_us_next;
                start_reg   <= start_next;
            end
            if (cfg_valid && cfg_ready) begin
                dbl_reg <= cfg_data;
            end
        end
    end

endmodule

@@ hdl/csnm_queue.sv @@
// short command queue between front end and back end
module csnm_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  csnm_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output csnm_pkg::cmd_t       head_cmd,
    output csnm_pkg::q_stat_t    stat
);
    import csnm_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

@@ hdl/csnm_back.sv @@
// back end: expands each command into output words through an output register
module csnm_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  csnm_pkg::cmd_t       head_cmd,
    input  csnm_pkg::q_stat_t    q_stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // out_char
    output logic                 m_tuser,   // out_run_last
    output logic                 m_tlast    // out_name_end
);
    import csnm_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg;
    logic [CHAR_W-1:0] data_reg;
    logic              user_reg, last_reg;
    logic              load, emit, run_last;
    logic [CHAR_W-1:0] byte_sel;

    assign load     = !valid_reg || m_tready;
    assign emit     = load && !q_stat.empty;
    assign run_last = (idx_reg == last_index(head_cmd.kind));
    assign pop      = emit && run_last;
    assign idx_next = run_last ? '0 : idx_reg + 1'b1;

    always_comb begin
        byte_sel = head_cmd.ch;
        unique case (head_cmd.kind)
            CMD_PASS: byte_sel = head_cmd.ch;
            CMD_US1:  byte_sel = CH_UNDERSCORE;
            CMD_US2:  byte_sel = CH_UNDERSCORE;
            CMD_ESC: begin
                unique case (idx_reg)
                    2'd0:    byte_sel = CH_ZERO;
                    2'd1:    byte_sel = CH_X;
                    2'd2:    byte_sel = hex_char(head_cmd.ch[7:4]);
                    default: byte_sel = hex_char(head_cmd.ch[3:0]);
                endcase
            end
            default:  byte_sel = head_cmd.ch;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            data_reg <= byte_sel;
            user_reg <= run_last;
            last_reg <= run_last && head_cmd.name_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= !q_stat.empty;
            end
            if (emit) begin
                idx_reg <= idx_next;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule
